>>> hw/rtl/cfe_pkg.sv
// Package for the calendar field editor: beat types, request, slot and done codes,
// and the month length lookup. No dependencies.
package cfe_pkg;

   localparam logic [2:0] REQ_LEFT   = 3'd0;
   localparam logic [2:0] REQ_RIGHT  = 3'd1;
   localparam logic [2:0] REQ_UP     = 3'd2;
   localparam logic [2:0] REQ_DOWN   = 3'd3;
   localparam logic [2:0] REQ_ESCAPE = 3'd4;
   localparam logic [2:0] REQ_ENTER  = 3'd5;
   localparam logic [2:0] REQ_LOAD   = 3'd6;

   localparam logic [2:0] SLOT_YEAR   = 3'd0;
   localparam logic [2:0] SLOT_MONTH  = 3'd1;
   localparam logic [2:0] SLOT_DAY    = 3'd2;
   localparam logic [2:0] SLOT_HOUR   = 3'd3;
   localparam logic [2:0] SLOT_MINUTE = 3'd4;
   localparam logic [2:0] SLOT_SET    = 3'd5;
   localparam logic [2:0] SLOT_CANCEL = 3'd6;

   localparam logic [1:0] DONE_EDIT   = 2'd0;
   localparam logic [1:0] DONE_CANCEL = 2'd1;
   localparam logic [1:0] DONE_COMMIT = 2'd2;

   localparam logic [11:0] YEAR_LO = 12'd2020;
   localparam logic [11:0] YEAR_HI = 12'd2099;
   localparam logic [3:0]  MONTH_HI = 4'd12;
   localparam logic [4:0]  HOUR_HI = 5'd23;
   localparam logic [5:0]  MINUTE_HI = 6'd59;

   localparam logic [4:0] MONTH_LEN [12] = '{
      5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
   };

   typedef struct packed {
      logic [2:0]  req_type;
      logic [13:0] load_year;
      logic [3:0]  load_month;
      logic [4:0]  load_day;
      logic [4:0]  load_hour;
      logic [5:0]  load_minute;
   } req_beat_type;

   typedef struct packed {
      logic [11:0] cur_year;
      logic [3:0]  cur_month;
      logic [4:0]  cur_day;
      logic [4:0]  cur_hour;
      logic [5:0]  cur_minute;
      logic [2:0]  focus_slot;
      logic [1:0]  done_code;
   } rsp_beat_type;

   // Year is held within 2020..2099, which has no century year, so leap is year % 4.
   function automatic logic [4:0] days_of(input logic [11:0] year, input logic [3:0] month);
      logic [4:0] len;
      len = 5'd31;
      if (month >= 4'd1 && month <= MONTH_HI) begin
         len = MONTH_LEN[month - 4'd1];
         if (month == 4'd2 && year[1:0] == 2'b00) begin
            len = 5'd29;
         end
      end
      return len;
   endfunction

endpackage

>>> hw/rtl/calendar_field_editor.sv
// Calendar field editor top level: key-driven date and time setting controller.
// Depends on cfe_pkg.

// Takes one key beat per cycle and returns one result beat per key. The key lands
// in an input register, then the field update, day clamp and focus move are done
// in one pass into the result register while the held fields update in the same
// edge. A stalled result blocks the input register only; with the result side
// free, a new beat is taken every cycle.
module calendar_field_editor (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cfe_pkg::req_beat_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cfe_pkg::rsp_beat_type rsp_data
);

   logic                  s1_valid_ff, s1_valid_in;
   cfe_pkg::req_beat_type s1_data_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   cfe_pkg::rsp_beat_type rsp_data_ff, rsp_data_in;

   logic [11:0] year_ff, year_in;
   logic [3:0]  month_ff, month_in;
   logic [4:0]  day_ff, day_in;
   logic [4:0]  hour_ff, hour_in;
   logic [5:0]  minute_ff, minute_in;
   logic [2:0]  focus_ff, focus_in;

   logic        out_ready;
   logic        advance;
   logic        req_accept;
   logic [1:0]  done;
   logic [4:0]  cur_len;
   logic [4:0]  new_len;
   logic [4:0]  day_step;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign advance    = s1_valid_ff && out_ready;
   assign req_stall  = s1_valid_ff && !out_ready;
   assign req_accept = req_valid && !req_stall;

   assign s1_valid_in  = req_accept ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);
   assign rsp_valid_in = advance ? 1'b1 : (out_ready ? 1'b0 : rsp_valid_ff);

   assign cur_len = cfe_pkg::days_of(year_ff, month_ff);

   always_comb begin
      year_in   = year_ff;
      month_in  = month_ff;
      day_step  = day_ff;
      hour_in   = hour_ff;
      minute_in = minute_ff;
      focus_in  = focus_ff;
      done      = cfe_pkg::DONE_EDIT;
      case (s1_data_ff.req_type)
         cfe_pkg::REQ_LEFT: begin
            focus_in = (focus_ff == cfe_pkg::SLOT_YEAR) ? cfe_pkg::SLOT_CANCEL
                                                        : focus_ff - 3'd1;
         end
         cfe_pkg::REQ_RIGHT: begin
            focus_in = (focus_ff >= cfe_pkg::SLOT_CANCEL) ? cfe_pkg::SLOT_YEAR
                                                          : focus_ff + 3'd1;
         end
         cfe_pkg::REQ_UP, cfe_pkg::REQ_DOWN: begin
            if (s1_data_ff.req_type == cfe_pkg::REQ_UP) begin
               case (focus_ff)
                  cfe_pkg::SLOT_YEAR:
                     year_in = (year_ff >= cfe_pkg::YEAR_HI) ? cfe_pkg::YEAR_LO
                                                              : year_ff + 12'd1;
                  cfe_pkg::SLOT_MONTH:
                     month_in = (month_ff >= cfe_pkg::MONTH_HI) ? 4'd1 : month_ff + 4'd1;
                  cfe_pkg::SLOT_DAY:
                     day_step = (day_ff >= cur_len) ? 5'd1 : day_ff + 5'd1;
                  cfe_pkg::SLOT_HOUR:
                     hour_in = (hour_ff >= cfe_pkg::HOUR_HI) ? 5'd0 : hour_ff + 5'd1;
                  cfe_pkg::SLOT_MINUTE:
                     minute_in = (minute_ff >= cfe_pkg::MINUTE_HI) ? 6'd0
                                                                   : minute_ff + 6'd1;
                  default: ;
               endcase
            end else begin
               case (focus_ff)
                  cfe_pkg::SLOT_YEAR:
                     year_in = (year_ff <= cfe_pkg::YEAR_LO) ? cfe_pkg::YEAR_HI
                                                              : year_ff - 12'd1;
                  cfe_pkg::SLOT_MONTH:
                     month_in = (month_ff <= 4'd1) ? cfe_pkg::MONTH_HI : month_ff - 4'd1;
                  cfe_pkg::SLOT_DAY:
                     day_step = (day_ff <= 5'd1) ? cur_len : day_ff - 5'd1;
                  cfe_pkg::SLOT_HOUR:
                     hour_in = (hour_ff == 5'd0) ? cfe_pkg::HOUR_HI : hour_ff - 5'd1;
                  cfe_pkg::SLOT_MINUTE:
                     minute_in = (minute_ff == 6'd0) ? cfe_pkg::MINUTE_HI
                                                     : minute_ff - 6'd1;
                  default: ;
               endcase
            end
         end
         cfe_pkg::REQ_ESCAPE: begin
            done = cfe_pkg::DONE_CANCEL;
         end
         cfe_pkg::REQ_ENTER: begin
            if (focus_ff == cfe_pkg::SLOT_CANCEL) begin
               done = cfe_pkg::DONE_CANCEL;
            end else if (focus_ff == cfe_pkg::SLOT_SET) begin
               done = cfe_pkg::DONE_COMMIT;
            end else begin
               focus_in = cfe_pkg::SLOT_SET;
            end
         end
         cfe_pkg::REQ_LOAD: begin
            if (s1_data_ff.load_year < 14'(cfe_pkg::YEAR_LO) ||
                s1_data_ff.load_year > 14'(cfe_pkg::YEAR_HI)) begin
               year_in = cfe_pkg::YEAR_LO;
            end else begin
               year_in = s1_data_ff.load_year[11:0];
            end
            if (s1_data_ff.load_month == 4'd0) begin
               month_in = 4'd1;
            end else if (s1_data_ff.load_month > cfe_pkg::MONTH_HI) begin
               month_in = cfe_pkg::MONTH_HI;
            end else begin
               month_in = s1_data_ff.load_month;
            end
            day_step  = s1_data_ff.load_day;
            hour_in   = (s1_data_ff.load_hour > cfe_pkg::HOUR_HI) ? cfe_pkg::HOUR_HI
                                                                  : s1_data_ff.load_hour;
            minute_in = (s1_data_ff.load_minute > cfe_pkg::MINUTE_HI) ? cfe_pkg::MINUTE_HI
                                                                      : s1_data_ff.load_minute;
            focus_in  = cfe_pkg::SLOT_YEAR;
         end
         default: ;
      endcase
   end

   // Day always kept within the (possibly new) month.
   assign new_len = cfe_pkg::days_of(year_in, month_in);

   always_comb begin
      if (day_step > new_len) begin
         day_in = new_len;
      end else if (day_step == 5'd0) begin
         day_in = 5'd1;
      end else begin
         day_in = day_step;
      end
   end

   always_comb begin
      rsp_data_in.cur_year   = year_in;
      rsp_data_in.cur_month  = month_in;
      rsp_data_in.cur_day    = day_in;
      rsp_data_in.cur_hour   = hour_in;
      rsp_data_in.cur_minute = minute_in;
      rsp_data_in.focus_slot = focus_in;
      rsp_data_in.done_code  = done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         year_ff      <= cfe_pkg::YEAR_LO;
         month_ff     <= 4'd1;
         day_ff       <= 5'd1;
         hour_ff      <= 5'd0;
         minute_ff    <= 6'd0;
         focus_ff     <= cfe_pkg::SLOT_YEAR;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (advance) begin
            year_ff   <= year_in;
            month_ff  <= month_in;
            day_ff    <= day_in;
            hour_ff   <= hour_in;
            minute_ff <= minute_in;
            focus_ff  <= focus_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_year_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.cur_year >= cfe_pkg::YEAR_LO &&
                        rsp_data_ff.cur_year <= cfe_pkg::YEAR_HI))
      else $error("result year out of range");

   a_day_fits: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.cur_day >= 5'd1 &&
                        rsp_data_ff.cur_day <= cfe_pkg::days_of(rsp_data_ff.cur_year,
                                                                rsp_data_ff.cur_month)))
      else $error("result day outside month");

   a_state_matches: assert property (@(posedge clock) disable iff (reset)
      advance |=> (year_ff == rsp_data_ff.cur_year && day_ff == rsp_data_ff.cur_day &&
                   focus_ff == rsp_data_ff.focus_slot))
      else $error("held fields differ from last result");

   a_advance_valid: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced beat lost");

endmodule
